// ----- sv/slrp_pkg.sv -----
`default_nettype none

package slrp_pkg;

  typedef enum logic [1:0] {
    OpStamp   = 2'd0,
    OpClimate = 2'd1,
    OpSetting = 2'd2,
    OpBattery = 2'd3
  } op_e;

  localparam logic [3:0] StampTag        = 4'hE;
  localparam logic [1:0] ClimateTag      = 2'b00;
  localparam logic [1:0] SettingTag      = 2'b01;
  localparam logic [3:0] BatteryCodeInit = 4'd12;

  typedef struct packed {
    logic        two_recs;
    logic [31:0] stamp_word;
    logic [31:0] data_word;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

endpackage

`default_nettype wire

// ----- sv/slrp_ifs.sv -----
`default_nettype none

interface slrp_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] now_seconds;
  logic [15:0] temp_raw;
  logic [15:0] humidity_raw;
  logic        occupied;
  logic [6:0]  bottom_heat;
  logic [6:0]  back_heat;
  logic [6:0]  bottom_cool;
  logic [6:0]  back_cool;
  logic [15:0] battery_mv;
  logic        battery_good;

  modport source (
    output valid, operation, now_seconds, temp_raw, humidity_raw, occupied,
           bottom_heat, back_heat, bottom_cool, back_cool, battery_mv, battery_good,
    input  ready
  );
  modport sink (
    input  valid, operation, now_seconds, temp_raw, humidity_raw, occupied,
           bottom_heat, back_heat, bottom_cool, back_cool, battery_mv, battery_good,
    output ready
  );
endinterface

interface slrp_rec_if;
  logic        valid;
  logic        ready;
  logic [31:0] record_word;
  logic        last_record;

  modport source (output valid, record_word, last_record, input ready);
  modport sink (input valid, record_word, last_record, output ready);
endinterface

interface slrp_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] battery_type_code;

  modport source (output valid, battery_type_code, input ready);
  modport sink (input valid, battery_type_code, output ready);
endinterface

`default_nettype wire

// ----- sv/slrp_front.sv -----
`default_nettype none

module slrp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  slrp_evt_if.sink           evt_i,
  slrp_cfg_if.sink           cfg_i,
  input  logic               q_ready_i,
  output logic               push_o,
  output slrp_pkg::entry_t   entry_o
);

  logic [31:0]      last_q, last_d;
  logic [3:0]       code_q, code_d;
  logic [31:0]      elapsed;
  logic             over;
  logic [10:0]      el_w;
  logic [13:0]      temp;
  logic [11:0]      hum;
  slrp_pkg::op_e    op;

  assign cfg_i.ready = 1'b1;
  assign evt_i.ready = q_ready_i;
  assign push_o      = evt_i.valid && q_ready_i;

  assign op      = slrp_pkg::op_e'(evt_i.operation);
  assign elapsed = evt_i.now_seconds - last_q;
  assign temp    = evt_i.temp_raw[15:2];
  assign hum     = evt_i.humidity_raw[15:4];

  always_comb begin
    unique case (op)
      slrp_pkg::OpStamp:   over = 1'b0;
      slrp_pkg::OpClimate: over = |elapsed[31:3];
      slrp_pkg::OpSetting: over = |elapsed[31:2];
      slrp_pkg::OpBattery: over = |elapsed[31:11];
      default:             over = 1'b0;
    endcase
  end

  assign el_w = over ? 11'd0 : elapsed[10:0];

  always_comb begin
    entry_o.two_recs   = over;
    entry_o.stamp_word = {slrp_pkg::StampTag, evt_i.now_seconds[27:0]};
    unique case (op)
      slrp_pkg::OpStamp:   entry_o.data_word = {slrp_pkg::StampTag, evt_i.now_seconds[27:0]};
      slrp_pkg::OpClimate: entry_o.data_word = {slrp_pkg::ClimateTag, el_w[2:0],
                                                evt_i.occupied, hum, temp};
      slrp_pkg::OpSetting: entry_o.data_word = {slrp_pkg::SettingTag, el_w[1:0],
                                                evt_i.bottom_heat, evt_i.back_heat,
                                                evt_i.bottom_cool, evt_i.back_cool};
      slrp_pkg::OpBattery: entry_o.data_word = {code_q, evt_i.battery_good, el_w,
                                                evt_i.battery_mv};
      default:             entry_o.data_word = '0;
    endcase
  end

  // kept time lands on now_seconds after every event kind
  assign last_d = push_o ? evt_i.now_seconds : last_q;
  assign code_d = (cfg_i.valid && cfg_i.ready) ? cfg_i.battery_type_code : code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      code_q <= slrp_pkg::BatteryCodeInit;
    end else begin
      last_q <= last_d;
      code_q <= code_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/slrp_queue.sv -----
`default_nettype none

module slrp_queue #(
  parameter int Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  slrp_pkg::entry_t   entry_i,
  output logic               ready_o,
  input  logic               pop_i,
  output slrp_pkg::q_head_t  head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  slrp_pkg::entry_t  mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_pop;

  assign ready_o      = (cnt_q != CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rd_q];
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !ready_o))
    else $error("queue push while full");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// ----- sv/slrp_back.sv -----
`default_nettype none

module slrp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  slrp_pkg::q_head_t  head_i,
  output logic               pop_o,
  slrp_rec_if.source         rec_o
);

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_word_q, out_word_d;
  logic        out_last_q, out_last_d;
  logic        pend_valid_q, pend_valid_d;
  logic [31:0] pend_word_q, pend_word_d;
  logic        load;

  assign load  = !out_valid_q || rec_o.ready;
  assign pop_o = load && !pend_valid_q && head_i.valid;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_word_d   = out_word_q;
    out_last_d   = out_last_q;
    pend_valid_d = pend_valid_q;
    pend_word_d  = pend_word_q;
    if (load) begin
      if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_word_d   = pend_word_q;
        out_last_d   = 1'b1;
        pend_valid_d = 1'b0;
      end else if (head_i.valid) begin
        out_valid_d = 1'b1;
        if (head_i.entry.two_recs) begin
          out_word_d   = head_i.entry.stamp_word;
          out_last_d   = 1'b0;
          pend_valid_d = 1'b1;
          pend_word_d  = head_i.entry.data_word;
        end else begin
          out_word_d = head_i.entry.data_word;
          out_last_d = 1'b1;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q  <= out_word_d;
    out_last_q  <= out_last_d;
    pend_word_q <= pend_word_d;
  end

  assign rec_o.valid       = out_valid_q;
  assign rec_o.record_word = out_word_q;
  assign rec_o.last_record = out_last_q;

`ifndef SYNTHESIS
  a_pend_behind_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (out_valid_q && !out_last_q))
    else $error("pending record without a leading stamp record");
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rec_o.ready && !out_last_q) |=> (out_valid_q && out_last_q))
    else $error("data record did not follow its stamp record");
`endif

endmodule

`default_nettype wire

// ----- sv/sensor_log_record_packer_core.sv -----
`default_nettype none

// channel  | dir | handshake     | payload
// evt_i    | in  | valid / ready | operation, now_seconds, sensor and setting fields
// rec_o    | out | valid / ready | record_word, last_record
// cfg_i    | in  | valid / ready | battery_type_code
//
// One event enters per cycle while the front queue has room.
// Each event yields one or two records; the output register moves one per cycle
// while rec_o.ready is high, and a leading timestamp record goes before its data.
// Reset clears the kept time to zero and the battery type code to 12.
// A stalled output fills the queue; evt_i.ready drops once it holds QueueDepth events.

module sensor_log_record_packer_core #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slrp_evt_if.sink    evt_i,
  slrp_cfg_if.sink    cfg_i,
  slrp_rec_if.source  rec_o
);

  logic               push;
  logic               q_ready;
  logic               pop;
  slrp_pkg::entry_t   entry;
  slrp_pkg::q_head_t  head;

  slrp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .evt_i     (evt_i),
    .cfg_i     (cfg_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .entry_o   (entry)
  );

  slrp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .ready_o (q_ready),
    .pop_i   (pop),
    .head_o  (head)
  );

  slrp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .rec_o  (rec_o)
  );

endmodule

`default_nettype wire

// ----- bench/tb_sensor_log_record_packer_core.sv -----
module tb_sensor_log_record_packer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 2000;
  localparam int PhaseItems = 250;
  localparam int HoldCycles = 300;

  typedef struct packed {
    slrp_pkg::op_e op;
    logic [31:0]   secs;
    logic [15:0]   temp;
    logic [15:0]   hum;
    logic          occ;
    logic [6:0]    bot_heat;
    logic [6:0]    bk_heat;
    logic [6:0]    bot_cool;
    logic [6:0]    bk_cool;
    logic [15:0]   mv;
    logic          good;
  } packer_event_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } log_record_t;

  class log_record_board;
    log_record_t due_records[$];
    logic [31:0] kept_time;
    logic [3:0]  battery_code;
    int          faults;

    function new();
      kept_time    = '0;
      battery_code = slrp_pkg::BatteryCodeInit;
      faults       = 0;
    endfunction

    function void set_battery_code(input logic [3:0] code);
      battery_code = code;
    endfunction

    function int pending();
      return due_records.size();
    endfunction

    function void note_event(input packer_event_t ev);
      logic [31:0] gap;
      logic [31:0] limit;
      logic [31:0] stamp;
      logic [31:0] word;
      stamp = {slrp_pkg::StampTag, ev.secs[27:0]};
      if (ev.op == slrp_pkg::OpStamp) begin
        due_records.push_back('{stamp, 1'b1});
        kept_time = ev.secs;
        return;
      end
      case (ev.op)
        slrp_pkg::OpClimate: limit = 32'd7;
        slrp_pkg::OpSetting: limit = 32'd3;
        default:             limit = 32'd2047;
      endcase
      gap = ev.secs - kept_time;
      if (gap > limit) begin
        due_records.push_back('{stamp, 1'b0});
        kept_time = ev.secs;
        gap       = '0;
      end
      case (ev.op)
        slrp_pkg::OpClimate: word = {slrp_pkg::ClimateTag, gap[2:0], ev.occ, ev.hum[15:4],
                                     ev.temp[15:2]};
        slrp_pkg::OpSetting: word = {slrp_pkg::SettingTag, gap[1:0], ev.bot_heat, ev.bk_heat,
                                     ev.bot_cool, ev.bk_cool};
        default:             word = {battery_code, ev.good, gap[10:0], ev.mv};
      endcase
      kept_time += gap;
      due_records.push_back('{word, 1'b1});
    endfunction

    function void check_record(input log_record_t got);
      log_record_t want;
      if (due_records.size() == 0) begin
        $error("record_word: expected none, actual %h", got.word);
        faults++;
        return;
      end
      want = due_records.pop_front();
      if (got.word !== want.word) begin
        $error("record_word: expected %h, actual %h", want.word, got.word);
        faults++;
      end
      if (got.last !== want.last) begin
        $error("last_record: expected %b, actual %b", want.last, got.last);
        faults++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int   hold_req;
  logic [31:0] sim_now;

  log_record_board board = new();

  slrp_evt_if evt ();
  slrp_cfg_if cfg ();
  slrp_rec_if rec ();

  sensor_log_record_packer_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .evt_i  (evt),
    .cfg_i  (cfg),
    .rec_o  (rec)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic packer_event_t blank_event(input slrp_pkg::op_e op,
                                                input logic [31:0] secs);
    packer_event_t ev;
    ev      = '0;
    ev.op   = op;
    ev.secs = secs;
    return ev;
  endfunction

  function automatic packer_event_t random_event();
    packer_event_t ev;
    int pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) begin
      ev.op = slrp_pkg::OpStamp;
    end else begin
      ev.op = slrp_pkg::op_e'($urandom_range(1, 3));
    end
    if (pick < 30) begin
      sim_now += $urandom_range(0, 9);
    end else if (pick < 45) begin
      sim_now += $urandom_range(0, 4);
    end else if (pick < 60) begin
      sim_now += $urandom_range(2040, 2055);
    end else if (pick < 72) begin
      sim_now += $urandom_range(0, 2047);
    end else if (pick < 80) begin
      sim_now -= $urandom_range(1, 64);
    end else if (pick < 88) begin
      sim_now = $urandom;
    end else if (pick < 94) begin
      sim_now = 32'hFFFF_FFFF - $urandom_range(0, 8);
    end else begin
      sim_now += $urandom;
    end
    ev.secs     = sim_now;
    ev.temp     = 16'($urandom);
    ev.hum      = 16'($urandom);
    ev.occ      = 1'($urandom);
    ev.bot_heat = 7'($urandom);
    ev.bk_heat  = 7'($urandom);
    ev.bot_cool = 7'($urandom);
    ev.bk_cool  = 7'($urandom);
    ev.mv       = 16'($urandom);
    ev.good     = 1'($urandom);
    return ev;
  endfunction

  task automatic send_event(input packer_event_t ev);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 16) begin
      evt.valid = 1'b0;
      @(negedge clk);
    end
    evt.valid        = 1'b1;
    evt.operation    = ev.op;
    evt.now_seconds  = ev.secs;
    evt.temp_raw     = ev.temp;
    evt.humidity_raw = ev.hum;
    evt.occupied     = ev.occ;
    evt.bottom_heat  = ev.bot_heat;
    evt.back_heat    = ev.bk_heat;
    evt.bottom_cool  = ev.bot_cool;
    evt.back_cool    = ev.bk_cool;
    evt.battery_mv   = ev.mv;
    evt.battery_good = ev.good;
    do @(posedge clk); while (!evt.ready);
  endtask

  task automatic drain_records();
    @(negedge clk);
    evt.valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_battery_code(input logic [3:0] code);
    @(negedge clk);
    cfg.valid             = 1'b1;
    cfg.battery_type_code = code;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    rec.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        rec.ready = 1'b0;
        hold_left--;
      end else begin
        rec.ready = calm || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  always @(posedge clk) begin
    packer_event_t seen;
    if (rec.valid && rec.ready) begin
      board.check_record('{rec.record_word, rec.last_record});
    end
    if (evt.valid && evt.ready) begin
      seen.op       = slrp_pkg::op_e'(evt.operation);
      seen.secs     = evt.now_seconds;
      seen.temp     = evt.temp_raw;
      seen.hum      = evt.humidity_raw;
      seen.occ      = evt.occupied;
      seen.bot_heat = evt.bottom_heat;
      seen.bk_heat  = evt.back_heat;
      seen.bot_cool = evt.bottom_cool;
      seen.bk_cool  = evt.back_cool;
      seen.mv       = evt.battery_mv;
      seen.good     = evt.battery_good;
      board.note_event(seen);
    end
    if (cfg.valid && cfg.ready) begin
      board.set_battery_code(cfg.battery_type_code);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((evt.valid && evt.ready) || (rec.valid && rec.ready) ||
          (cfg.valid && cfg.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    packer_event_t ev;
    logic [3:0] code;
    rst_n                 = 1'b0;
    calm                  = 1'b0;
    hold_req              = 0;
    sim_now               = '0;
    evt.valid             = 1'b0;
    evt.operation         = slrp_pkg::OpStamp;
    evt.now_seconds       = '0;
    evt.temp_raw          = '0;
    evt.humidity_raw      = '0;
    evt.occupied          = 1'b0;
    evt.bottom_heat       = '0;
    evt.back_heat         = '0;
    evt.bottom_cool       = '0;
    evt.back_cool         = '0;
    evt.battery_mv        = '0;
    evt.battery_good      = 1'b0;
    cfg.valid             = 1'b0;
    cfg.battery_type_code = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_event(blank_event(slrp_pkg::OpClimate, 32'd0));
    ev = blank_event(slrp_pkg::OpClimate, 32'd7);
    ev.temp = '1;
    ev.hum  = '1;
    ev.occ  = 1'b1;
    send_event(ev);
    send_event(blank_event(slrp_pkg::OpClimate, 32'd15));
    ev = blank_event(slrp_pkg::OpSetting, 32'd18);
    ev.bot_heat = '1;
    ev.bk_heat  = '1;
    ev.bot_cool = '1;
    ev.bk_cool  = '1;
    send_event(ev);
    send_event(blank_event(slrp_pkg::OpSetting, 32'd22));
    ev = blank_event(slrp_pkg::OpBattery, 32'd2069);
    ev.mv   = '1;
    ev.good = 1'b1;
    send_event(ev);
    send_event(blank_event(slrp_pkg::OpBattery, 32'd4117));
    send_event(blank_event(slrp_pkg::OpStamp, 32'hFFFF_FFFF));
    ev = blank_event(slrp_pkg::OpClimate, 32'd4);
    ev.occ = 1'b1;
    send_event(ev);
    send_event(blank_event(slrp_pkg::OpBattery, 32'd4));
    send_event(blank_event(slrp_pkg::OpSetting, 32'd2));
    ev = blank_event(slrp_pkg::OpSetting, 32'd3);
    ev.bot_heat = 7'h55;
    ev.bk_heat  = 7'h2A;
    ev.bot_cool = 7'h55;
    ev.bk_cool  = 7'h2A;
    send_event(ev);
    send_event(blank_event(slrp_pkg::OpStamp, 32'hF000_0000));
    ev = blank_event(slrp_pkg::OpBattery, 32'hF000_0003);
    ev.mv = 16'hA5C3;
    send_event(ev);
    ev = blank_event(slrp_pkg::OpClimate, 32'hF000_0006);
    ev.temp = 16'h0003;
    ev.hum  = 16'h000F;
    send_event(ev);
    send_event(blank_event(slrp_pkg::OpSetting, 32'h0000_0010));
    send_event(blank_event(slrp_pkg::OpClimate, 32'h0000_0017));
    sim_now = 32'h0000_0017;

    for (int p = 0; p < 5; p++) begin
      drain_records();
      case (p)
        0:       code = 4'h0;
        1:       code = 4'hF;
        3:       code = slrp_pkg::BatteryCodeInit;
        default: code = 4'($urandom_range(0, 15));
      endcase
      write_battery_code(code);
      calm = (p == 1);
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 2 && i == 40) hold_req = HoldCycles;
        if (p == 3 && i == 125) drain_records();
        send_event(random_event());
      end
    end
    drain_records();
    repeat (20) @(posedge clk);
    if (board.faults == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/slrp_pkg.sv
sv/slrp_ifs.sv
sv/slrp_front.sv
sv/slrp_queue.sv
sv/slrp_back.sv
sv/sensor_log_record_packer_core.sv
bench/tb_sensor_log_record_packer_core.sv
